// ----- design/rsps_pkg.sv -----
package rsps_pkg;

    // image geometry (width minus one, height minus one)
    localparam int WM        = 399;
    localparam int HM        = 224;
    // direction scaling: dx = (32*col - 16*WM)*HM, dy = (2*row - HM)*9*WM, dz = -9*WM*HM
    localparam int DX_OFS    = 16 * WM;
    localparam int DY_SCALE  = 9 * WM;
    localparam int DZ_MAG    = 9 * WM * HM;

    // pipeline depths of the iterative units
    localparam int SQRT_STEPS = 22;
    localparam int DIV_STEPS  = 17;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_index_t;

    // input item
    typedef struct packed {
        logic [8:0] pixel_column;
        logic [7:0] pixel_row;
    } pixel_t;

    // result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       sphere_hit;
    } color_t;

    // side data carried alongside the sky path
    typedef struct packed {
        logic [19:0] dy_mag;
        logic        dy_neg;
        logic        hit;
    } side_t;

    // pipeline control shared by all sections
    typedef struct packed {
        logic en;
    } pipe_ctrl_t;

endpackage

// ----- design/rsps_ray.sv -----
module rsps_ray import rsps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pipe_ctrl_t         ctrl,
    input  logic               pix_valid,
    input  pixel_t             pix,
    input  logic signed [15:0] cx,
    input  logic signed [15:0] cy,
    input  logic signed [15:0] cz,
    input  logic        [14:0] rad,
    output logic               ray_valid,
    output logic        [42:0] dd,
    output side_t              side
);

    localparam logic [42:0] DZ_SQ = 43'(DZ_MAG) * 43'(DZ_MAG);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1: direction and centre squares
    logic signed [23:0] dx1_reg;
    logic signed [21:0] dy1_reg;
    logic [30:0] sqx1_reg, sqy1_reg, sqz1_reg;
    logic [29:0] sqr1_reg;
    // stage 2: products
    logic [43:0] dxsq2_reg;
    logic [39:0] dysq2_reg;
    logic signed [39:0] px2_reg;
    logic signed [37:0] py2_reg;
    logic signed [36:0] pz2_reg;
    logic signed [32:0] k2_reg;
    logic [19:0] dym2_reg;
    logic dyn2_reg;
    // stage 3: sums
    logic [42:0] dd3_reg;
    logic signed [40:0] p3_reg;
    logic [31:0] ku3_reg;
    logic kneg3_reg;
    logic [19:0] dym3_reg;
    logic dyn3_reg;
    // stage 4: partial products of the discriminant
    logic [39:0] paa4_reg, pab4_reg, pbb4_reg;
    logic [53:0] qh4_reg;
    logic [52:0] ql4_reg;
    logic kneg4_reg;
    logic [42:0] dd4_reg;
    logic [19:0] dym4_reg;
    logic dyn4_reg;
    // stage 5: assembled wide products
    logic [79:0] psq5_reg;
    logic [75:0] q5_reg;
    logic kneg5_reg;
    logic [42:0] dd5_reg;
    logic [19:0] dym5_reg;
    logic dyn5_reg;
    // stage 6: hit decision
    logic [42:0] dd6_reg;
    side_t side6_reg;

    logic signed [24:0] dx_w;
    logic signed [22:0] dy_w;
    logic signed [31:0] sqx_w, sqy_w, sqz_w;
    logic [29:0] sqr_w;
    logic [23:0] dxa_w;
    logic [21:0] dya_w;
    logic [43:0] dxsq_w;
    logic [39:0] dysq_w;
    logic signed [39:0] px_w;
    logic signed [37:0] py_w;
    logic signed [36:0] pz_w;
    logic signed [32:0] k_w;
    logic [42:0] dd_w;
    logic signed [40:0] p_w;
    logic [40:0] pa_w;
    logic [39:0] pm_w;
    logic [79:0] psq_w;
    logic [75:0] q_w;

    always_comb
    begin
        dx_w  = ($signed({16'd0, pix.pixel_column}) * 25'sd32 - 25'(DX_OFS)) * 25'(HM);
        dy_w  = ($signed({15'd0, pix.pixel_row}) * 23'sd2 - 23'(HM)) * 23'(DY_SCALE);
        sqx_w = cx * cx;
        sqy_w = cy * cy;
        sqz_w = cz * cz;
        sqr_w = rad * rad;

        dxa_w  = dx1_reg[23] ? 24'(-dx1_reg) : 24'(dx1_reg);
        dya_w  = dy1_reg[21] ? 22'(-dy1_reg) : 22'(dy1_reg);
        dxsq_w = 44'(dxa_w[21:0]) * 44'(dxa_w[21:0]);
        dysq_w = 40'(dya_w[19:0]) * 40'(dya_w[19:0]);
        px_w   = cx * dx1_reg;
        py_w   = cy * dy1_reg;
        pz_w   = cz * 21'(-DZ_MAG);
        k_w    = $signed({2'b00, sqx1_reg}) + $signed({2'b00, sqy1_reg})
               + $signed({2'b00, sqz1_reg}) - $signed({3'b000, sqr1_reg});

        dd_w = 43'(dxsq2_reg) + 43'(dysq2_reg) + DZ_SQ;
        p_w  = 41'(px2_reg) + 41'(py2_reg) + 41'(pz2_reg);

        pa_w = p3_reg[40] ? 41'(-p3_reg) : 41'(p3_reg);
        pm_w = pa_w[39:0];

        psq_w = (80'(paa4_reg) << 40) + (80'(pab4_reg) << 21) + 80'(pbb4_reg);
        q_w   = (76'(qh4_reg) << 21) + 76'(ql4_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            v1_reg <= pix_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            dx1_reg  <= dx_w[23:0];
            dy1_reg  <= dy_w[21:0];
            sqx1_reg <= sqx_w[30:0];
            sqy1_reg <= sqy_w[30:0];
            sqz1_reg <= sqz_w[30:0];
            sqr1_reg <= sqr_w;

            dxsq2_reg <= dxsq_w;
            dysq2_reg <= dysq_w;
            px2_reg   <= px_w;
            py2_reg   <= py_w;
            pz2_reg   <= pz_w;
            k2_reg    <= k_w;
            dym2_reg  <= dya_w[19:0];
            dyn2_reg  <= dy1_reg[21];

            dd3_reg   <= dd_w;
            p3_reg    <= p_w;
            ku3_reg   <= k2_reg[31:0];
            kneg3_reg <= k2_reg[32];
            dym3_reg  <= dym2_reg;
            dyn3_reg  <= dyn2_reg;

            paa4_reg  <= 40'(pm_w[39:20]) * 40'(pm_w[39:20]);
            pab4_reg  <= 40'(pm_w[39:20]) * 40'(pm_w[19:0]);
            pbb4_reg  <= 40'(pm_w[19:0]) * 40'(pm_w[19:0]);
            qh4_reg   <= 54'(dd3_reg[42:21]) * 54'(ku3_reg);
            ql4_reg   <= 53'(dd3_reg[20:0]) * 53'(ku3_reg);
            kneg4_reg <= kneg3_reg;
            dd4_reg   <= dd3_reg;
            dym4_reg  <= dym3_reg;
            dyn4_reg  <= dyn3_reg;

            psq5_reg  <= psq_w;
            q5_reg    <= q_w;
            kneg5_reg <= kneg4_reg;
            dd5_reg   <= dd4_reg;
            dym5_reg  <= dym4_reg;
            dyn5_reg  <= dyn4_reg;

            // origin inside sphere always hits; grazing counts as a miss
            side6_reg.hit    <= kneg5_reg | (psq5_reg > 80'(q5_reg));
            side6_reg.dy_mag <= dym5_reg;
            side6_reg.dy_neg <= dyn5_reg;
            dd6_reg          <= dd5_reg;
        end
    end

    assign ray_valid = v6_reg;
    assign dd        = dd6_reg;
    assign side      = side6_reg;

endmodule

// ----- design/rsps_sqrt.sv -----
module rsps_sqrt import rsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pipe_ctrl_t  ctrl,
    input  logic        ray_valid,
    input  logic [42:0] dd,
    input  side_t       side_in,
    output logic        len_valid,
    output logic [21:0] len,
    output side_t       side_out
);

    typedef struct packed {
        logic [43:0] n;
        logic [23:0] rem;
        logic [21:0] root;
        side_t       side;
    } sq_stage_t;

    // one root bit: bring down two radicand bits, trial-subtract 4*root+1
    function automatic sq_stage_t sq_step(input sq_stage_t s);
        sq_stage_t r;
        logic [25:0] rs;
        logic [25:0] test;
        r    = s;
        rs   = {s.rem, s.n[43:42]};
        test = {2'b00, s.root, 2'b01};
        r.n  = {s.n[41:0], 2'b00};
        if (rs >= test)
        begin
            r.rem  = 24'(rs - test);
            r.root = {s.root[20:0], 1'b1};
        end
        else
        begin
            r.rem  = rs[23:0];
            r.root = {s.root[20:0], 1'b0};
        end
        return r;
    endfunction

    sq_stage_t stg_reg [SQRT_STEPS];
    logic      vld_reg [SQRT_STEPS];
    sq_stage_t stg_in  [SQRT_STEPS];

    always_comb
    begin
        stg_in[0].n    = {1'b0, dd};
        stg_in[0].rem  = '0;
        stg_in[0].root = '0;
        stg_in[0].side = side_in;
    end

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_stage
        if (g > 0)
        begin : g_link
            assign stg_in[g] = stg_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (ctrl.en)
            begin
                vld_reg[g] <= (g == 0) ? ray_valid : vld_reg[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.en)
            begin
                stg_reg[g] <= sq_step(stg_in[g]);
            end
        end
    end

    assign len_valid = vld_reg[SQRT_STEPS-1];
    assign len       = stg_reg[SQRT_STEPS-1].root;
    assign side_out  = stg_reg[SQRT_STEPS-1].side;

endmodule

// ----- design/rsps_div.sv -----
module rsps_div import rsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pipe_ctrl_t  ctrl,
    input  logic        len_valid,
    input  logic [21:0] len,
    input  side_t       side_in,
    output logic        quo_valid,
    output logic [16:0] quo,
    output side_t       side_out
);

    // |dy| <= len, so (|dy| << 16) / len fits 17 bits and the top part starts below len
    typedef struct packed {
        logic [21:0] rem;
        logic [21:0] d;
        logic [16:0] dbits;
        logic [16:0] q;
        side_t       side;
    } dv_stage_t;

    // one quotient bit of a restoring division
    function automatic dv_stage_t dv_step(input dv_stage_t s);
        dv_stage_t r;
        logic [22:0] rs;
        r       = s;
        rs      = {s.rem, s.dbits[16]};
        r.dbits = {s.dbits[15:0], 1'b0};
        if (rs >= 23'(s.d))
        begin
            r.rem = 22'(rs - 23'(s.d));
            r.q   = {s.q[15:0], 1'b1};
        end
        else
        begin
            r.rem = rs[21:0];
            r.q   = {s.q[15:0], 1'b0};
        end
        return r;
    endfunction

    dv_stage_t stg_reg [DIV_STEPS];
    logic      vld_reg [DIV_STEPS];
    dv_stage_t stg_in  [DIV_STEPS];

    always_comb
    begin
        stg_in[0].rem   = {3'b000, side_in.dy_mag[19:1]};
        stg_in[0].d     = len;
        stg_in[0].dbits = {side_in.dy_mag[0], 16'd0};
        stg_in[0].q     = '0;
        stg_in[0].side  = side_in;
    end

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_stage
        if (g > 0)
        begin : g_link
            assign stg_in[g] = stg_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (ctrl.en)
            begin
                vld_reg[g] <= (g == 0) ? len_valid : vld_reg[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.en)
            begin
                stg_reg[g] <= dv_step(stg_in[g]);
            end
        end
    end

    assign quo_valid = vld_reg[DIV_STEPS-1];
    assign quo       = stg_reg[DIV_STEPS-1].q;
    assign side_out  = stg_reg[DIV_STEPS-1].side;

endmodule

// ----- design/rsps_colour.sv -----
module rsps_colour import rsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pipe_ctrl_t  ctrl,
    input  logic        quo_valid,
    input  logic [16:0] quo,
    input  side_t       side_in,
    output logic        color_valid,
    output color_t      color
);

    // floor(v / 1000) and floor(v / 5000) by reciprocal, one correction step
    localparam logic [22:0] RECIP_R = 23'd4294967;
    localparam logic [19:0] RECIP_G = 20'd858993;
    localparam logic [17:0] SCALE   = 18'd255999;
    localparam logic [9:0]  DIV_R   = 10'd1000;
    localparam logic [12:0] DIV_G   = 13'd5000;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [17:0] ar1_reg;
    logic [19:0] ag1_reg;
    logic        hit1_reg, hit2_reg, hit3_reg, hit4_reg;
    logic [35:0] pr2_reg;
    logic [37:0] pg2_reg;
    logic [18:0] vr3_reg, vr4_reg;
    logic [20:0] vg3_reg, vg4_reg;
    logic [41:0] mr3_reg;
    logic [40:0] mg3_reg;
    logic [9:0]  qr4_reg;
    logic [8:0]  qg4_reg;
    logic [19:0] cr4_reg;
    logic [21:0] cg4_reg;
    color_t      col5_reg;

    logic [17:0] sum_w;
    logic [16:0] t_w;
    logic [19:0] remr_w;
    logic [21:0] remg_w;
    logic [10:0] fr_w;
    logic [9:0]  fg_w;

    always_comb
    begin
        // sky parameter t = (y + 1) / 2 in Q16
        sum_w = side_in.dy_neg ? (18'd65536 - 18'(quo)) : (18'd65536 + 18'(quo));
        t_w   = sum_w[17:1];

        remr_w = 20'(vr4_reg) - cr4_reg;
        remg_w = 22'(vg4_reg) - cg4_reg;
        fr_w   = (remr_w >= 20'(DIV_R)) ? 11'(qr4_reg) + 11'd1 : 11'(qr4_reg);
        fg_w   = (remg_w >= 22'(DIV_G)) ? 10'(qg4_reg) + 10'd1 : 10'(qg4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            v1_reg <= quo_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            ar1_reg  <= 18'd131072 - 18'(t_w);
            ag1_reg  <= 20'd655360 - 20'(t_w) * 20'd3;
            hit1_reg <= side_in.hit;

            pr2_reg  <= 36'(ar1_reg) * 36'(SCALE);
            pg2_reg  <= 38'(ag1_reg) * 38'(SCALE);
            hit2_reg <= hit1_reg;

            vr3_reg  <= pr2_reg[35:17];
            vg3_reg  <= pg2_reg[37:17];
            mr3_reg  <= 42'(pr2_reg[35:17]) * 42'(RECIP_R);
            mg3_reg  <= 41'(pg2_reg[37:17]) * 41'(RECIP_G);
            hit3_reg <= hit2_reg;

            vr4_reg  <= vr3_reg;
            vg4_reg  <= vg3_reg;
            qr4_reg  <= mr3_reg[41:32];
            qg4_reg  <= mg3_reg[40:32];
            cr4_reg  <= 20'(mr3_reg[41:32]) * 20'(DIV_R);
            cg4_reg  <= 22'(mg3_reg[40:32]) * 22'(DIV_G);
            hit4_reg <= hit3_reg;

            // hit is pure red, otherwise sky blend, clamped
            if (hit4_reg)
            begin
                col5_reg.red   <= 8'd255;
                col5_reg.green <= 8'd0;
                col5_reg.blue  <= 8'd0;
            end
            else
            begin
                col5_reg.red   <= (fr_w > 11'd255) ? 8'd255 : fr_w[7:0];
                col5_reg.green <= (fg_w > 10'd255) ? 8'd255 : fg_w[7:0];
                col5_reg.blue  <= 8'd255;
            end
            col5_reg.sphere_hit <= hit4_reg;
        end
    end

    assign color_valid = v5_reg;
    assign color       = col5_reg;

endmodule

// ----- design/ray_sphere_pixel_shader.sv -----
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------
// pixel    | pixel_valid / pixel_stall  | pixel  (pixel_column, pixel_row)
// color    | color_valid / color_stall  | color  (red, green, blue, sphere_hit)
// config   | cfg_write                  | cfg_index, cfg_data (16 bits)
//
// One pixel item per clock unless a result stall holds the pipeline; the
// stages are 6 ray/hit stages, 22 square root stages at one root bit each,
// 17 divider stages at one quotient bit each, and 5 colour stages.
// All stages advance together; a stall on the result freezes the whole
// pipeline and pixel_stall follows it, so nothing is lost or repeated.
// Reset clears the valid bits and loads the default sphere registers.
module ray_sphere_pixel_shader import rsps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  pixel_t      pixel,
    output logic        color_valid,
    input  logic        color_stall,
    output color_t      color,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic signed [15:0] cx_reg, cy_reg, cz_reg;
    logic        [14:0] rad_reg;

    pipe_ctrl_t ctrl;
    logic        ray_valid, len_valid, quo_valid;
    logic [42:0] dd;
    logic [21:0] len;
    logic [16:0] quo;
    side_t       side_ray, side_len, side_quo;

    // sphere registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= 16'sd0;
            cy_reg  <= 16'sd0;
            cz_reg  <= -16'sd4096;
            rad_reg <= 15'd2048;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTER_X: cx_reg  <= cfg_data;
                CFG_CENTER_Y: cy_reg  <= cfg_data;
                CFG_CENTER_Z: cz_reg  <= cfg_data;
                CFG_RADIUS:   rad_reg <= cfg_data[14:0];
            endcase
        end
    end

    // global advance: hold everything while a result waits
    assign ctrl.en     = !(color_valid && color_stall);
    assign pixel_stall = !ctrl.en;

    rsps_ray u_ray
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .pix_valid (pixel_valid),
        .pix       (pixel),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .cz        (cz_reg),
        .rad       (rad_reg),
        .ray_valid (ray_valid),
        .dd        (dd),
        .side      (side_ray)
    );

    rsps_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .ray_valid (ray_valid),
        .dd        (dd),
        .side_in   (side_ray),
        .len_valid (len_valid),
        .len       (len),
        .side_out  (side_len)
    );

    rsps_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .len_valid (len_valid),
        .len       (len),
        .side_in   (side_len),
        .quo_valid (quo_valid),
        .quo       (quo),
        .side_out  (side_quo)
    );

    rsps_colour u_colour
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .quo_valid   (quo_valid),
        .quo         (quo),
        .side_in     (side_quo),
        .color_valid (color_valid),
        .color       (color)
    );

endmodule
